### hw/rtl/hfr_pkg.sv
// hfr_pkg: shared constants, command type and character decode helpers
// for the hex frame receiver. No dependencies.
`timescale 1ns / 1ps

package hfr_pkg;

    // Frame buffer sizing
    localparam int MAX_CHARS   = 12;
    localparam int STORE_DEPTH = MAX_CHARS / 2;
    localparam int CNT_W       = $clog2(MAX_CHARS + 1);
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Control characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_D0  = 8'h30;
    localparam logic [7:0] CH_D9  = 8'h39;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;

    // Result kinds
    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_MSG = 1'b1;

    typedef enum logic [1:0] {
        OP_STX,
        OP_ETX,
        OP_HEX
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [3:0] nibble;
        logic       active;
    } cmd_t;

    // Nibble value of an upper-case hex character (caller checks validity)
    function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
        logic [3:0] val;
        if (ch <= CH_D9) begin
            val = ch[3:0];
        end else begin
            val = ch[3:0] + 4'd9;
        end
        return val;
    endfunction

endpackage

### hw/rtl/hfr_front.sv
// hfr_front: accepts received characters, classifies them and drops
// anything that is not STX, ETX or upper-case hex. Uses hfr_pkg.
`timescale 1ns / 1ps

module hfr_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_rx_char,
    input  logic          s_detector_active,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output hfr_pkg::cmd_t cmd
);
    import hfr_pkg::*;

    logic cmd_valid_reg, cmd_valid_next;
    cmd_t cmd_reg, cmd_next;
    cmd_t cls;
    logic keep;
    logic take;

    // Classify the incoming character
    always_comb begin
        cls.op     = OP_HEX;
        cls.nibble = hex_nibble(s_rx_char);
        cls.active = s_detector_active;
        keep       = 1'b1;
        case (s_rx_char) inside
            CH_STX:         cls.op = OP_STX;
            CH_ETX:         cls.op = OP_ETX;
            [CH_D0:CH_D9]:  cls.op = OP_HEX;
            [CH_UA:CH_UF]:  cls.op = OP_HEX;
            default:        keep = 1'b0;
        endcase
    end

    assign s_ready = !cmd_valid_reg || cmd_ready;
    assign take    = s_valid && s_ready;

    // Command register feeding the queue
    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (cmd_valid_reg && cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
        if (take && keep) begin
            cmd_valid_next = 1'b1;
            cmd_next       = cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

### hw/rtl/hfr_fifo.sv
// hfr_fifo: short command queue between the front and the back.
// Uses hfr_pkg for the command type and depth.
`timescale 1ns / 1ps

module hfr_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  hfr_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output hfr_pkg::cmd_t rd_data
);
    import hfr_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              push, pop;

    assign wr_ready = (fill_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Fill level tracks the pointer distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != (QPTR_W + 1)'(QUEUE_DEPTH)) |->
            (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == fill_reg[QPTR_W-1:0]))
        else $error("hfr_fifo: fill level disagrees with pointers");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("hfr_fifo: full queue with unequal pointers");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("hfr_fifo: push did not raise fill level");

endmodule

### hw/rtl/hfr_back.sv
// hfr_back: frame state, nibble packing into the byte store and readout
// of acknowledge and message bytes on ETX. Uses hfr_pkg.
`timescale 1ns / 1ps

module hfr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  hfr_pkg::cmd_t cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_kind,
    output logic [7:0]    m_data,
    output logic          m_last
);
    import hfr_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_ACK,
        S_FETCH,
        S_SEND
    } state_t;

    state_t           state_reg, state_next;
    logic             waiting_reg, waiting_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       hi_nib_reg, hi_nib_next;
    logic [IDX_W-1:0] msg_left_reg, msg_left_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    logic [7:0]       store_mem [STORE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_byte;

    logic             cmd_pop;
    logic             out_free;
    logic [CNT_W-2:0] whole_bytes;

    assign cmd_ready   = (state_reg == S_RUN);
    assign cmd_pop     = cmd_valid && cmd_ready;
    assign out_free    = !out_valid_reg || m_ready;
    assign whole_bytes = count_reg[CNT_W-1:1];
    assign wr_idx      = IDX_W'(count_reg >> 1);
    assign wr_byte     = {hi_nib_reg, cmd.nibble};

    // Command execution and readout sequencing
    always_comb begin
        state_next     = state_reg;
        waiting_next   = waiting_reg;
        count_next     = count_reg;
        hi_nib_next    = hi_nib_reg;
        msg_left_next  = msg_left_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_RUN: begin
                if (cmd_pop) begin
                    if (waiting_reg) begin
                        // everything but STX is ignored before a frame
                        if (cmd.op == OP_STX) begin
                            waiting_next = 1'b0;
                            count_next   = '0;
                        end
                    end else begin
                        case (cmd.op)
                            OP_ETX: begin
                                waiting_next = 1'b1;
                                count_next   = '0;
                                rd_idx_next  = '0;
                                // checksum byte is dropped
                                msg_left_next = (whole_bytes > 1)
                                    ? IDX_W'(whole_bytes - 1'b1) : '0;
                                if (cmd.active) begin
                                    state_next = S_ACK;
                                end else if (whole_bytes > 1) begin
                                    state_next = S_FETCH;
                                end
                            end
                            OP_HEX: begin
                                if (count_reg < CNT_W'(MAX_CHARS)) begin
                                    if (count_reg[0]) begin
                                        wr_en = 1'b1;
                                    end else begin
                                        hi_nib_next = cmd.nibble;
                                    end
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            default: begin
                                // repeated STX inside a frame is ignored
                            end
                        endcase
                    end
                end
            end
            S_ACK: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_data_next  = CH_ACK;
                    out_last_next  = (msg_left_reg == '0);
                    state_next     = (msg_left_reg == '0) ? S_RUN : S_FETCH;
                end
            end
            S_FETCH: begin
                state_next = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_MSG;
                    out_data_next  = rd_data_reg;
                    out_last_next  = (msg_left_reg == IDX_W'(1));
                    msg_left_next  = msg_left_reg - 1'b1;
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    state_next     = (msg_left_reg == IDX_W'(1)) ? S_RUN : S_FETCH;
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RUN;
            waiting_reg   <= 1'b1;
            count_reg     <= '0;
            msg_left_reg  <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            waiting_reg   <= waiting_next;
            count_reg     <= count_next;
            msg_left_reg  <= msg_left_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
        hi_nib_reg   <= hi_nib_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_idx] <= wr_byte;
        end
        rd_data_reg <= store_mem[rd_idx_reg];
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_data  = out_data_reg;
    assign m_last  = out_last_reg;

    // Commands are only taken while no readout is in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (state_reg == S_RUN))
        else $error("hfr_back: command taken during readout");

    // A readout byte is always owed when sending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEND || state_reg == S_FETCH) |-> (msg_left_reg != '0))
        else $error("hfr_back: readout with nothing left");

    // Readout happens only after the frame has closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_RUN) |-> waiting_reg)
        else $error("hfr_back: readout while a frame is open");

    // Read address stays inside the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (rd_idx_reg < IDX_W'(STORE_DEPTH - 1)))
        else $error("hfr_back: read address beyond message bytes");

endmodule

### hw/rtl/hex_frame_receiver_core.sv
// Hex frame receiver top level: front classifier, command queue, back end.
// Throughput: one character per cycle while no frame is being read out.
// A character passes the front register and the queue to the back end; on ETX
// the acknowledge (detector active) is loaded first, then each message byte is
// read from the store and then loaded for output; the queue fills during readout.
// Reset (aresetn, synchronous, active low) returns to waiting for STX and
// empties the queue; the byte store is not cleared.
`timescale 1ns / 1ps

module hex_frame_receiver_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_char,
    input  logic       s_detector_active,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_data,
    output logic       m_last
);
    import hfr_pkg::*;

    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic back_valid, back_ready;
    cmd_t back_cmd;

    // Character classification
    hfr_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_char         (s_rx_char),
        .s_detector_active (s_detector_active),
        .cmd_valid         (front_valid),
        .cmd_ready         (front_ready),
        .cmd               (front_cmd)
    );

    // Command queue
    hfr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_cmd)
    );

    // Frame handling and result output
    hfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_data    (m_data),
        .m_last    (m_last)
    );

endmodule

### test/hfr_frame_check.sv
// hfr_frame_check: watches both channels of the hex frame receiver, predicts the
// result transactions for every accepted character and compares them in order.
// Depends on hfr_pkg for the control characters, result kinds and buffer sizing.
`timescale 1ns / 1ps

module hfr_frame_check (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_char,
    input  logic       s_detector_active,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_kind,
    input  logic [7:0] m_data,
    input  logic       m_last,
    output int         mismatches,
    output int         outstanding
);
    import hfr_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } frame_result_t;

    frame_result_t      result_q[$];
    int                 err_count;

    // Shadow of the receiver state
    logic               awaiting_stx;
    logic [CNT_W-1:0]   chars_taken;
    logic [7:0]         decoded_bytes [STORE_DEPTH];

    initial begin
        err_count    = 0;
        mismatches   = 0;
        outstanding  = 0;
        awaiting_stx = 1'b1;
        chars_taken  = '0;
    end

    function automatic logic is_upper_hex(input logic [7:0] ch);
        return (ch >= CH_D0 && ch <= CH_D9) || (ch >= CH_UA && ch <= CH_UF);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] ch);
        logic [7:0] val;
        if (ch <= CH_D9) begin
            val = ch - CH_D0;
        end else begin
            val = ch - CH_UA + 8'd10;
        end
        return val[3:0];
    endfunction

    // Work out the results caused by one accepted character
    task automatic decode_char(input logic [7:0] ch, input logic active);
        int            whole_bytes;
        int            total;
        int            n;
        int            slot;
        frame_result_t res;
        whole_bytes = int'(chars_taken >> 1);
        if (awaiting_stx) begin
            if (ch == CH_STX) begin
                awaiting_stx = 1'b0;
                chars_taken  = '0;
            end
        end else if (ch == CH_ETX) begin
            // acknowledge first, then every whole byte but the checksum
            total = (active ? 1 : 0) + ((whole_bytes > 1) ? whole_bytes - 1 : 0);
            n = 0;
            if (active) begin
                res.kind = KIND_ACK;
                res.data = CH_ACK;
                res.last = (n == total - 1);
                result_q.push_back(res);
                n++;
            end
            for (int k = 0; k + 1 < whole_bytes && k < STORE_DEPTH; k++) begin
                res.kind = KIND_MSG;
                res.data = decoded_bytes[k];
                res.last = (n == total - 1);
                result_q.push_back(res);
                n++;
            end
            awaiting_stx = 1'b1;
            chars_taken  = '0;
        end else if (int'(chars_taken) < MAX_CHARS && is_upper_hex(ch)) begin
            slot = whole_bytes;
            if (slot < STORE_DEPTH) begin
                if (chars_taken[0]) begin
                    decoded_bytes[slot] = {decoded_bytes[slot][3:0], nibble_of(ch)};
                end else begin
                    decoded_bytes[slot] = {4'h0, nibble_of(ch)};
                end
            end
            chars_taken = chars_taken + 1'b1;
        end
    endtask

    // Compare one result transaction against the oldest expectation
    task automatic check_result(input frame_result_t got);
        frame_result_t want;
        if (result_q.size() == 0) begin
            err_count++;
            if (err_count <= 10) begin
                $display("[%0t] unexpected result: kind=%0b data=%02h last=%0b",
                         $realtime, got.kind, got.data, got.last);
            end
        end else begin
            want = result_q.pop_front();
            if (want.kind !== got.kind || want.data !== got.data
                || want.last !== got.last) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("[%0t] result mismatch: ", $realtime,
                             "expected kind=%0b data=%02h last=%0b, ",
                             want.kind, want.data, want.last,
                             "got kind=%0b data=%02h last=%0b",
                             got.kind, got.data, got.last);
                end
            end
        end
    endtask

    // Results are checked before the same edge's input, which cannot affect them
    always @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_stx = 1'b1;
            chars_taken  = '0;
            result_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result({m_kind, m_data, m_last});
            end
            if (s_valid && s_ready) begin
                decode_char(s_rx_char, s_detector_active);
            end
        end
        mismatches  <= err_count;
        outstanding <= result_q.size();
    end

endmodule

### test/testbench.sv
// testbench: drives framed hex character streams into hex_frame_receiver_core with
// bursty input and a stalling result side; hfr_frame_check does the checking.
// Depends on hfr_pkg, hex_frame_receiver_core and hfr_frame_check.
`timescale 1ns / 1ps

module testbench;
    import hfr_pkg::*;

    localparam int RANDOM_ITEMS = 310;
    localparam int IDLE_LIMIT   = 400;
    localparam int TAIL_CYCLES  = 30;

    logic       aclk              = 1'b0;
    logic       aresetn           = 1'b0;
    logic       s_valid           = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_char         = 8'h00;
    logic       s_detector_active = 1'b0;
    logic       m_valid;
    logic       m_ready           = 1'b0;
    logic       m_kind;
    logic [7:0] m_data;
    logic       m_last;

    int         mismatches;
    int         outstanding;
    int         burst_left        = 0;
    int         idle_cycles       = 0;

    logic [15:0] ready_pattern    = 16'hFFFF;
    int          pattern_age      = 0;

    always #5 aclk = ~aclk;

    hex_frame_receiver_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_char         (s_rx_char),
        .s_detector_active (s_detector_active),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_data            (m_data),
        .m_last            (m_last)
    );

    hfr_frame_check i_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_char         (s_rx_char),
        .s_detector_active (s_detector_active),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_data            (m_data),
        .m_last            (m_last),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    // Result side: a rotating ready pattern, swapped for a new one now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready       <= 1'b0;
            ready_pattern <= 16'hFFFF;
            pattern_age   <= 0;
        end else begin
            m_ready <= ready_pattern[0];
            if (pattern_age == 47) begin
                pattern_age <= 0;
                case ($urandom_range(0, 3))
                    0: ready_pattern <= 16'hFFFF;
                    1: ready_pattern <= 16'h0001;
                    2: ready_pattern <= 16'h5555;
                    default: ready_pattern <= 16'($urandom) | 16'h0001;
                endcase
            end else begin
                pattern_age   <= pattern_age + 1;
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one character and wait for its transaction; gaps fall between bursts
    task automatic send_char(input logic [7:0] ch, input logic active);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid           <= 1'b1;
        s_rx_char         <= ch;
        s_detector_active <= active;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_text(input string text, input logic active);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i], active);
        end
    endtask

    initial begin
        int         sent;
        int         frame_len;
        logic [7:0] ch;
        logic [3:0] nib;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Noise while waiting for STX, ETX outside a frame
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(CH_ETX, 1'b1);
        // Full buffer, extra character ignored, detector inactive
        send_char(CH_STX, 1'b1);
        send_text("0123456789AF", 1'b0);
        send_char("7", 1'b1);
        send_char(CH_ETX, 1'b0);
        // Lower case and repeated STX dropped, odd trailing nibble, single byte
        send_char(CH_STX, 1'b0);
        send_text("AaB", 1'b1);
        send_char(CH_STX, 1'b1);
        send_char("C", 1'b0);
        send_char(CH_ETX, 1'b1);
        // Empty frame: acknowledge alone
        send_char(CH_STX, 1'b0);
        send_char(CH_ETX, 1'b1);

        // Random frames, mostly well formed
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            repeat ($urandom_range(0, 2)) begin
                send_char(8'($urandom_range(0, 255)), 1'($urandom));
            end
            send_char(CH_STX, 1'($urandom));
            sent++;
            frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 16)
                                                    : $urandom_range(0, 11);
            repeat (frame_len) begin
                if ($urandom_range(0, 9) == 0) begin
                    // junk inside the frame, sometimes lower-case hex
                    if ($urandom_range(0, 2) == 0) begin
                        ch = 8'($urandom_range(8'h61, 8'h66));
                    end else begin
                        ch = 8'($urandom_range(0, 255));
                        while ((ch >= CH_D0 && ch <= CH_D9) || (ch >= CH_UA && ch <= CH_UF)
                               || ch == CH_ETX) begin
                            ch = 8'($urandom_range(0, 255));
                        end
                    end
                    send_char(ch, 1'($urandom));
                end else begin
                    nib = 4'($urandom_range(0, 15));
                    ch  = (nib < 4'd10) ? CH_D0 + 8'(nib) : CH_UA + 8'(nib) - 8'd10;
                    send_char(ch, 1'($urandom));
                    sent++;
                end
            end
            send_char(CH_ETX, 1'($urandom));
            sent++;
        end
        s_valid <= 1'b0;

        // Let the checker register the last character's expectations, then drain
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
